FILE: sv/pae_pkg.sv
// Shared types, character codes and defaults for the parenthesized-argument extractor.
`default_nettype none

package pae_pkg;

  // Largest number of characters that the argument store holds
  localparam int MAX_ARG_CHARS_DEF = 63;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_INDEX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN      = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] WANTED_INDEX_RST = 8'd1;
  localparam logic [6:0] MAX_LEN_RST      = 7'd64;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Parser modes
  typedef enum logic [2:0] {
    M_SEEK   = 3'd0,
    M_NORMAL = 3'd1,
    M_DQUOTE = 3'd2,
    M_SQUOTE = 3'd3,
    M_DONE   = 3'd4
  } mode_t;

  // Answer sequencer states
  typedef enum logic [2:0] {
    E_IDLE     = 3'd0,
    E_HEAD_RD  = 3'd1,
    E_HEAD_CHK = 3'd2,
    E_TAIL_RD  = 3'd3,
    E_TAIL_CHK = 3'd4,
    E_OUT_RD   = 3'd5,
    E_OUT_SEND = 3'd6,
    E_EMPTY    = 3'd7
  } emit_state_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       ok;
    logic       last;
  } res_t;

  // Status of the answer sequencer toward the top level
  typedef struct packed {
    logic busy;
    logic load;
    res_t res;
  } emit_stat_t;

endpackage

`default_nettype wire

FILE: sv/pae_store.sv
// Argument character store: one write port, one registered read port.
`default_nettype none

module pae_store #(
  parameter int MAX_ARG_CHARS = pae_pkg::MAX_ARG_CHARS_DEF,
  parameter int AW = (MAX_ARG_CHARS > 1) ? $clog2(MAX_ARG_CHARS) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [MAX_ARG_CHARS];

  // Write kept characters
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: sv/pae_emit.sv
// Answer sequencer: trims blanks off the stored argument and walks it out byte by byte.
`default_nettype none

module pae_emit #(
  parameter int MAX_ARG_CHARS = pae_pkg::MAX_ARG_CHARS_DEF,
  parameter int CW = $clog2(MAX_ARG_CHARS + 1),
  parameter int AW = (MAX_ARG_CHARS > 1) ? $clog2(MAX_ARG_CHARS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CW-1:0]       count,
  input  logic                out_free,
  output logic [AW-1:0]       rd_addr,
  input  logic [7:0]          rd_data,
  output pae_pkg::emit_stat_t stat
);
  import pae_pkg::*;

  emit_state_t state, state_next;
  logic [CW-1:0] s, s_next;
  logic [CW-1:0] e, e_next;
  logic [CW-1:0] s_p1, e_m1;
  logic          blank;

  // Shared index step and blank compare
  assign s_p1  = s + CW'(1);
  assign e_m1  = e - CW'(1);
  assign blank = (rd_data == CH_SPACE) || (rd_data == CH_TAB);

  // Tail scan reads below the end mark, all else reads at the head mark
  assign rd_addr = (state == E_TAIL_RD) ? e_m1[AW-1:0] : s[AW-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      E_IDLE: begin
        if (start) begin
          state_next = (count == '0) ? E_EMPTY : E_HEAD_RD;
        end
      end
      E_HEAD_RD:  state_next = E_HEAD_CHK;
      E_HEAD_CHK: begin
        if (blank) begin
          state_next = (s_p1 >= e) ? E_EMPTY : E_HEAD_RD;
        end else begin
          state_next = E_TAIL_RD;
        end
      end
      E_TAIL_RD:  state_next = E_TAIL_CHK;
      E_TAIL_CHK: state_next = blank ? E_TAIL_RD : E_OUT_RD;
      E_OUT_RD:   state_next = E_OUT_SEND;
      E_OUT_SEND: begin
        if (out_free) begin
          state_next = (s_p1 == e) ? E_IDLE : E_OUT_RD;
        end
      end
      E_EMPTY: begin
        if (out_free) begin
          state_next = E_IDLE;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  // Outputs and mark updates
  always_comb begin
    s_next         = s;
    e_next         = e;
    stat.busy      = (state != E_IDLE);
    stat.load      = 1'b0;
    stat.res       = '0;
    unique case (state)
      E_IDLE: begin
        if (start) begin
          s_next = '0;
          e_next = count;
        end
      end
      E_HEAD_CHK: begin
        if (blank) begin
          s_next = s_p1;
        end
      end
      E_TAIL_CHK: begin
        if (blank) begin
          e_next = e_m1;
        end
      end
      E_OUT_SEND: begin
        if (out_free) begin
          stat.load         = 1'b1;
          stat.res.out_byte = rd_data;
          stat.res.has_byte = 1'b1;
          stat.res.ok       = 1'b1;
          stat.res.last     = (s_p1 == e);
          s_next            = s_p1;
        end
      end
      E_EMPTY: begin
        if (out_free) begin
          stat.load     = 1'b1;
          stat.res.ok   = 1'b1;
          stat.res.last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Head and end marks
  always_ff @(posedge clk) begin
    s <= s_next;
    e <= e_next;
  end

endmodule

`default_nettype wire

FILE: sv/paren_argument_extractor.sv
// Top level: character parser, configuration, result register and checks.
// Latency: a no-parenthesis or error result is valid in the cycle after the code 0 that
// causes it. Throughput: one character per cycle while parsing and the output register is
// free. The closing ')', or the comma that ends the wanted argument, starts the answer
// sequencer, which holds input while it trims leading and trailing blanks and sends each
// output byte or an empty answer. Reset clears configuration, mode, argument counter, fill
// count, sequencer and output valid, not the argument store.
`default_nettype none

module paren_argument_extractor #(
  parameter int MAX_ARG_CHARS = pae_pkg::MAX_ARG_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] char_code
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] out_byte
  output logic [1:0]                     m_tuser,   // [0] has_byte, [1] ok
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [pae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);
  import pae_pkg::*;

  localparam int CW = $clog2(MAX_ARG_CHARS + 1);
  localparam int AW = (MAX_ARG_CHARS > 1) ? $clog2(MAX_ARG_CHARS) : 1;

  logic [7:0]    wanted_index;
  logic [6:0]    max_len;
  mode_t         mode, mode_next;
  logic [7:0]    current_arg;
  logic [CW-1:0] kept_count;

  logic          s_fire;
  logic          out_free;
  logic [6:0]    keep_limit;
  logic          can_keep;
  logic          keep_req;
  logic          arg_reset;
  logic          arg_inc;
  logic          emit_start;
  logic          par_load;
  res_t          par_res;
  res_t          out_res;
  emit_stat_t    emit_st;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !emit_st.busy && out_free;

  // Keep limit is max_len-1 (zero for max_len 0); the kept count never passes the store depth
  assign keep_limit = (max_len == 7'd0) ? 7'd0 : max_len - 7'd1;
  assign can_keep   = (current_arg == wanted_index) && (7'(kept_count) < keep_limit) &&
                      (kept_count < CW'(MAX_ARG_CHARS));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_index <= WANTED_INDEX_RST;
      max_len      <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WANTED_INDEX: wanted_index <= cfg_data;
        REG_MAX_LEN:      max_len      <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Parser next mode
  always_comb begin
    mode_next = mode;
    if (s_fire) begin
      unique case (mode)
        M_NORMAL: begin
          if (s_tdata == CH_NUL) begin
            mode_next = M_SEEK;
          end else if (s_tdata == CH_RPAREN) begin
            mode_next = M_DONE;
          end else if (s_tdata == CH_DQUOTE) begin
            mode_next = M_DQUOTE;
          end else if (s_tdata == CH_SQUOTE) begin
            mode_next = M_SQUOTE;
          end else if (s_tdata == CH_COMMA && current_arg == wanted_index) begin
            mode_next = M_DONE;
          end
        end
        M_DQUOTE: begin
          if (s_tdata == CH_NUL) begin
            mode_next = M_SEEK;
          end else if (s_tdata == CH_DQUOTE) begin
            mode_next = M_NORMAL;
          end
        end
        M_SQUOTE: begin
          if (s_tdata == CH_NUL) begin
            mode_next = M_SEEK;
          end else if (s_tdata == CH_SQUOTE) begin
            mode_next = M_NORMAL;
          end
        end
        M_DONE: begin
          if (s_tdata == CH_NUL) begin
            mode_next = M_SEEK;
          end
        end
        default: begin
          if (s_tdata == CH_NUL) begin
            mode_next = M_SEEK;
          end else if (s_tdata == CH_LPAREN) begin
            mode_next = M_NORMAL;
          end
        end
      endcase
    end
  end

  // Parser actions
  always_comb begin
    keep_req   = 1'b0;
    arg_reset  = 1'b0;
    arg_inc    = 1'b0;
    emit_start = 1'b0;
    par_load   = 1'b0;
    par_res    = '0;
    if (s_fire) begin
      unique case (mode)
        M_NORMAL: begin
          if (s_tdata == CH_NUL) begin
            par_load     = 1'b1;
            par_res.last = 1'b1;
          end else if (s_tdata == CH_RPAREN) begin
            emit_start = 1'b1;
          end else if (s_tdata == CH_DQUOTE || s_tdata == CH_SQUOTE) begin
            keep_req = 1'b0;
          end else if (s_tdata == CH_COMMA) begin
            if (current_arg == wanted_index) begin
              emit_start = 1'b1;
            end else begin
              arg_inc = 1'b1;
            end
          end else begin
            keep_req = can_keep;
          end
        end
        M_DQUOTE, M_SQUOTE: begin
          if (s_tdata == CH_NUL) begin
            par_load     = 1'b1;
            par_res.last = 1'b1;
          end else if (!(mode == M_DQUOTE && s_tdata == CH_DQUOTE) &&
                       !(mode == M_SQUOTE && s_tdata == CH_SQUOTE)) begin
            keep_req = can_keep;
          end
        end
        M_DONE: begin
        end
        default: begin
          if (s_tdata == CH_NUL) begin
            par_load     = 1'b1;
            par_res.ok   = 1'b1;
            par_res.last = 1'b1;
          end else if (s_tdata == CH_LPAREN) begin
            arg_reset = 1'b1;
          end
        end
      endcase
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_SEEK;
      current_arg <= 8'd1;
      kept_count  <= '0;
    end else begin
      mode <= mode_next;
      if (arg_reset) begin
        current_arg <= 8'd1;
        kept_count  <= '0;
      end else begin
        if (arg_inc && current_arg != 8'hFF) begin
          current_arg <= current_arg + 8'd1;
        end
        if (keep_req) begin
          kept_count <= kept_count + CW'(1);
        end
      end
    end
  end

  pae_store #(
    .MAX_ARG_CHARS(MAX_ARG_CHARS),
    .AW           (AW)
  ) u_store (
    .clk    (clk),
    .we     (keep_req),
    .wr_addr(kept_count[AW-1:0]),
    .wr_data(s_tdata),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  pae_emit #(
    .MAX_ARG_CHARS(MAX_ARG_CHARS),
    .CW           (CW),
    .AW           (AW)
  ) u_emit (
    .clk     (clk),
    .rst     (rst),
    .start   (emit_start),
    .count   (kept_count),
    .out_free(out_free),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .stat    (emit_st)
  );

  // Output register: hold until transfer, load from parser or sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (par_load || emit_st.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (par_load) begin
      out_res <= par_res;
    end else if (emit_st.load) begin
      out_res <= emit_st.res;
    end
  end

  assign m_tdata = out_res.out_byte;
  assign m_tuser = {out_res.ok, out_res.has_byte};
  assign m_tlast = out_res.last;

  // Fill count never passes the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CW'(MAX_ARG_CHARS))
    else $error("fill count beyond store depth");

  // A closing parenthesis starts the answer sequencer
  a_close_starts: assert property (@(posedge clk) disable iff (rst)
    (s_fire && mode == M_NORMAL && s_tdata == CH_RPAREN) |=> emit_st.busy)
    else $error("closing parenthesis did not start the answer");

  // An empty or error result is always the final one
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> m_tlast)
    else $error("byteless result not marked last");

  // An error result carries no byte
  a_err_nobyte: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (!m_tuser[0] && m_tdata == 8'd0))
    else $error("error result carries a byte");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the parenthesized-argument extractor.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pae_pkg::*;

  // Directed stimulus row: config, string (code 0 appended), optional typed answer
  typedef struct {
    logic [7:0] want;
    logic [6:0] size;
    string      text;
    bit         typed;
    bit         ok;
    string      reply;
  } row_t;

  localparam int NROWS = 7;
  localparam int RAND_CHARS = 100;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;

  row_t rows [NROWS] = '{
    // no parenthesis at all
    '{8'd1, 7'd64, "", 1'b1, 1'b1, ""},
    // blanks stripped, closing comma, trailing text ignored
    '{8'd1, 7'd64, "f( a\t,c)", 1'b1, 1'b1, "a"},
    // quoted spans: a double-quoted one with a comma inside, then a single-quoted one
    '{8'd1, 7'd64, "(\"x,\"'y')", 1'b0, 1'b1, ""},
    // unterminated list
    '{8'd1, 7'd64, "(a", 1'b1, 1'b0, ""},
    // unterminated quote
    '{8'd1, 7'd64, "('", 1'b1, 1'b0, ""},
    // buffer of two keeps one character, all-ones code
    '{8'd1, 7'd2, "(\377\001)", 1'b1, 1'b1, "\377"},
    // index zero never matches
    '{8'd0, 7'd64, "(a)", 1'b1, 1'b1, ""}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;   // [7:0] out_byte
  logic [1:0]           m_tuser;   // [0] has_byte, [1] ok
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  paren_argument_extractor u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Parser mirror state
  mode_t      pmode = M_SEEK;
  logic [7:0] arg_no = 8'd1;
  int         fill = 0;
  logic [7:0] store [MAX_ARG_CHARS_DEF];
  logic [7:0] want_arg = WANTED_INDEX_RST;
  logic [6:0] buf_size = MAX_LEN_RST;

  res_t       answer_q [$];   // expected answer bytes, oldest first
  res_t       fresh_q [$];    // answer bytes caused by the last character
  logic [7:0] char_q [$];     // characters waiting to be sent
  bit         use_typed = 1'b0;

  int err_count = 0;
  int src_idle = 18;
  int dst_idle = 47;
  int hold_req = 0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    err_count++;
    if (err_count <= 50)
      $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  // Keep a character of the wanted argument while the buffer has room
  function automatic void keep_char(logic [7:0] c);
    int lim;
    lim = (buf_size == 0) ? 0 : int'(buf_size) - 1;
    if (lim > MAX_ARG_CHARS_DEF)
      lim = MAX_ARG_CHARS_DEF;
    if (arg_no == want_arg && fill < lim) begin
      store[fill] = c;
      fill++;
    end
  endfunction

  // Strip blanks and queue the kept text, one byte per result
  function automatic void emit_answer();
    int s;
    int e;
    int i;
    s = 0;
    e = fill;
    while (s < e && is_blank(store[s]))
      s++;
    while (e > s && is_blank(store[e-1]))
      e--;
    pmode = M_DONE;
    if (s >= e)
      fresh_q.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
    else
      for (i = s; i < e; i++)
        fresh_q.push_back('{store[i], 1'b1, 1'b1, i == e - 1});
  endfunction

  // Advance the parser mirror by one character
  function automatic void parse_char(logic [7:0] c);
    case (pmode)
      M_NORMAL: begin
        if (c == CH_NUL) begin
          fresh_q.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
          pmode = M_SEEK;
        end else if (c == CH_RPAREN) begin
          emit_answer();
        end else if (c == CH_DQUOTE) begin
          pmode = M_DQUOTE;
        end else if (c == CH_SQUOTE) begin
          pmode = M_SQUOTE;
        end else if (c == CH_COMMA) begin
          if (arg_no == want_arg)
            emit_answer();
          else if (arg_no != 8'd255)
            arg_no++;
        end else begin
          keep_char(c);
        end
      end
      M_DQUOTE, M_SQUOTE: begin
        if (c == CH_NUL) begin
          fresh_q.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
          pmode = M_SEEK;
        end else if ((pmode == M_DQUOTE && c == CH_DQUOTE) ||
                     (pmode == M_SQUOTE && c == CH_SQUOTE)) begin
          pmode = M_NORMAL;
        end else begin
          keep_char(c);
        end
      end
      M_DONE: begin
        if (c == CH_NUL)
          pmode = M_SEEK;
      end
      default: begin
        if (c == CH_NUL) begin
          pmode = M_SEEK;
          fresh_q.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
        end else if (c == CH_LPAREN) begin
          pmode = M_NORMAL;
          arg_no = 8'd1;
          fill = 0;
        end
      end
    endcase
  endfunction

  // Offer one character, wait for its transfer, then predict
  task automatic send_char(logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = c;
    do @(posedge clk); while (!s_tready);
    parse_char(c);
    if (!use_typed)
      foreach (fresh_q[i])
        answer_q.push_back(fresh_q[i]);
    fresh_q.delete();
  endtask

  // Drop valid, drain every expected result, let the block go quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (answer_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == REG_WANTED_INDEX)
      want_arg = val;
    else
      buf_size = val[6:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_config();
    logic [7:0] w;
    logic [7:0] m;
    case ($urandom_range(9))
      0: w = 8'd0;
      1: w = 8'd255;
      2: w = 8'($urandom_range(255));
      default: w = 8'($urandom_range(1, 5));
    endcase
    case ($urandom_range(9))
      0: m = 8'd0;
      1: m = 8'd127;
      2: m = 8'd1;
      3: m = 8'($urandom_range(2, 6));
      4: m = 8'd65;
      5: m = 8'd64;
      default: m = 8'($urandom_range(2, 64));
    endcase
    write_reg(REG_WANTED_INDEX, w);
    write_reg(REG_MAX_LEN, m);
  endtask

  // Character that carries no meaning outside quotes
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      case ($urandom_range(9))
        0: c = ($urandom_range(1) != 0) ? CH_SPACE : CH_TAB;
        1, 2: c = 8'($urandom_range(1, 255));
        default: c = 8'($urandom_range(8'h21, 8'h7e));
      endcase
    end while (c == CH_NUL || c == CH_RPAREN || c == CH_DQUOTE ||
               c == CH_SQUOTE || c == CH_COMMA);
    return c;
  endfunction

  // Character inside a quoted span other than its closing quote
  function automatic logic [7:0] quoted_char(logic [7:0] q);
    logic [7:0] c;
    do begin
      if ($urandom_range(3) == 0)
        c = 8'($urandom_range(1, 255));
      else
        c = 8'($urandom_range(8'h20, 8'h7e));
    end while (c == CH_NUL || c == q);
    return c;
  endfunction

  // Append one string, mostly well formed, ending in code 0
  function automatic void build_string();
    int kind;
    int nargs;
    int a;
    int p;
    int k;
    int n;
    logic [7:0] q;
    kind = $urandom_range(99);
    if (kind < 10) begin
      // noise
      n = $urandom_range(1, 12);
      for (k = 0; k < n; k++)
        char_q.push_back(8'($urandom_range(1, 255)));
      char_q.push_back(CH_NUL);
      return;
    end
    n = $urandom_range(0, 4);
    for (k = 0; k < n; k++)
      char_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
    char_q.push_back(CH_LPAREN);
    nargs = $urandom_range(0, 5);
    for (a = 0; a < nargs; a++) begin
      if (a != 0)
        char_q.push_back(CH_COMMA);
      n = $urandom_range(0, 2);
      for (k = 0; k < n; k++)
        char_q.push_back(($urandom_range(1) != 0) ? CH_SPACE : CH_TAB);
      for (p = $urandom_range(0, 4); p > 0; p--) begin
        case ($urandom_range(9))
          0, 1: begin
            q = ($urandom_range(1) != 0) ? CH_DQUOTE : CH_SQUOTE;
            char_q.push_back(q);
            n = $urandom_range(0, 5);
            for (k = 0; k < n; k++)
              char_q.push_back(quoted_char(q));
            char_q.push_back(q);
          end
          2: begin
            // long run to reach truncation
            if ($urandom_range(3) == 0) begin
              n = $urandom_range(20, 70);
              for (k = 0; k < n; k++)
                char_q.push_back(8'($urandom_range(8'h41, 8'h5a)));
            end
          end
          default: begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
              char_q.push_back(plain_char());
          end
        endcase
      end
      n = $urandom_range(0, 2);
      for (k = 0; k < n; k++)
        char_q.push_back(($urandom_range(1) != 0) ? CH_SPACE : CH_TAB);
    end
    if (kind >= 20) begin
      char_q.push_back(CH_RPAREN);
      n = $urandom_range(0, 3);
      for (k = 0; k < n; k++)
        char_q.push_back(8'($urandom_range(1, 255)));
    end
    char_q.push_back(CH_NUL);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = ($urandom_range(99) >= dst_idle);
    end
  end

  // Check every result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    res_t got;
    res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata, m_tuser[0], m_tuser[1], m_tlast};
      if (answer_q.size() == 0) begin
        report($sformatf("unexpected result byte %h has %b ok %b last %b",
                         got.out_byte, got.has_byte, got.ok, got.last));
      end else begin
        exp_r = answer_q.pop_front();
        if (got.out_byte !== exp_r.out_byte || got.has_byte !== exp_r.has_byte ||
            got.ok !== exp_r.ok || got.last !== exp_r.last)
          report($sformatf("got byte %h has %b ok %b last %b, want %h %b %b %b",
                           got.out_byte, got.has_byte, got.ok, got.last,
                           exp_r.out_byte, exp_r.has_byte, exp_r.ok, exp_r.last));
      end
    end
  end

  initial begin : stimulus
    int r;
    int i;
    int sent;
    int next_cfg;
    bit pressed;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows
    for (r = 0; r < NROWS; r++) begin
      settle();
      write_reg(REG_WANTED_INDEX, rows[r].want);
      write_reg(REG_MAX_LEN, {1'b0, rows[r].size});
      use_typed = rows[r].typed;
      if (rows[r].typed) begin
        if (rows[r].reply.len() == 0)
          answer_q.push_back('{8'h00, 1'b0, rows[r].ok, 1'b1});
        else
          for (i = 0; i < rows[r].reply.len(); i++)
            answer_q.push_back('{rows[r].reply[i], 1'b1, 1'b1,
                                 i == rows[r].reply.len() - 1});
      end
      for (i = 0; i < rows[r].text.len(); i++)
        send_char(rows[r].text[i]);
      send_char(CH_NUL);
    end
    settle();
    use_typed = 1'b0;

    // Saturating argument counter: 254 commas reach argument 255
    write_reg(REG_WANTED_INDEX, 8'd255);
    write_reg(REG_MAX_LEN, 8'd64);
    send_char(CH_LPAREN);
    for (i = 0; i < 254; i++)
      send_char(CH_COMMA);
    send_char(8'h7a);
    send_char(CH_SPACE);
    send_char(8'h7a);
    send_char(CH_COMMA);
    send_char(CH_NUL);

    // Random strings, config changed at random points (mid-string too)
    sent = 0;
    next_cfg = 0;
    pressed = 1'b0;
    while (sent < RAND_CHARS || char_q.size() != 0) begin
      if (sent >= next_cfg && sent < RAND_CHARS) begin
        settle();
        random_config();
        next_cfg = sent + $urandom_range(25, 60);
      end
      if (sent < RAND_CHARS / 3) begin
        src_idle = 18;
        dst_idle = 47;
      end else if (sent < 2 * RAND_CHARS / 3) begin
        src_idle = 47;
        dst_idle = 18;
      end else begin
        src_idle = 0;
        dst_idle = 0;
        if (!pressed) begin
          hold_req = 1;
          pressed = 1'b1;
        end
      end
      if (char_q.size() == 0)
        build_string();
      send_char(char_q.pop_front());
      sent++;
    end

    settle();
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
